@@ hdl/gjk_pkg.sv @@
// Shared constants, widths and status codes for the GJK overlap test unit.
`default_nettype none
package gjk_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;
	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int SUM_W  = COORD_BITS + ADDR_W + 1;
	localparam int P_W    = COORD_BITS + 1;
	localparam int E_W    = COORD_BITS + 2;
	localparam int DIR_W  = SUM_W + CNT_W + 1;
	localparam int B_W    = (COORD_BITS + 3 > CNT_W + 1) ? COORD_BITS + 3 : CNT_W + 1;
	localparam int PROD_W = DIR_W + B_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int LIM_W  = 8;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 8'd100;

	localparam logic [2:0] ST_SEPARATED = 3'd0;
	localparam logic [2:0] ST_COLLISION = 3'd1;
	localparam logic [2:0] ST_LIMIT     = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_DROPPED   = 3'd4;
endpackage
`default_nettype wire

@@ hdl/gjk_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gjk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/gjk_polygon_overlap_test_2d_unit.sv @@
// Top level: 2D GJK convex polygon overlap test over a shared multiply-accumulate unit.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  in      | in_valid / in_stall  | body, vertex_x, vertex_y, last
//  out     | out_valid / out_stall| collision, status, iterations_used
//  cfg     | cfg_valid / cfg_ready| cfg_data (iteration limit)
//
// A vertex with last=0 is taken while idle. A vertex with last=1 starts the test:
// a setup step, then per support a scan of both stores and a check, a loop step per
// iteration, plus a line or triangle step per refinement and an emit step; all
// products go through the one shared multiplier.
// The result waits in an output register; a new pair loads while it is stalled.
// Reset clears counts, sums, the limit (to 100) and the sequencer; stores are not cleared.
`default_nettype none
module gjk_polygon_overlap_test_2d_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   body,
	input  wire logic signed [gjk_pkg::COORD_BITS-1:0] vertex_x,
	input  wire logic signed [gjk_pkg::COORD_BITS-1:0] vertex_y,
	input  wire logic                                   last,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        collision,
	output logic [2:0]                                  status,
	output logic [7:0]                                  iterations_used,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [gjk_pkg::LIM_W-1:0]              cfg_data
);
	import gjk_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_INIT, S_SCAN, S_CHECK, S_CROSS, S_LOOP, S_EMIT
	} state_t;

	state_t state_q;
	logic [2:0] st_q;
	logic [LIM_W-1:0] limit_q, iter_q;
	logic [CNT_W-1:0] cnt0_q, cnt1_q;
	logic signed [SUM_W-1:0] s0x_q, s0y_q, s1x_q, s1y_q;
	logic drop_q;
	logic signed [DIR_W-1:0] dx_q, dy_q;
	logic signed [ACC_W-1:0] acc_q, best_q;
	logic [ADDR_W-1:0] vidx_q;
	logic body_q, init_q, tri_q;
	logic signed [COORD_BITS-1:0] v1x_q, v1y_q, v2x_q, v2y_q;
	logic signed [P_W-1:0] pax_q, pay_q, p0x_q, p0y_q, p1x_q, p1y_q;
	logic kpos_q, kneg_q, g1pos_q, g1neg_q;
	logic [2:0] res_q;
	logic out_valid_q, collision_q;
	logic [2:0] status_q;
	logic [7:0] iters_q;

	logic in_xfer, we0, we1;
	logic [2*COORD_BITS-1:0] wdata, rd0, rd1;
	logic signed [COORD_BITS-1:0] rdx, rdy;

	logic signed [DIR_W-1:0] mul_a;
	logic signed [B_W-1:0] mul_b;
	logic mul_en, mul_clr, mul_neg;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] prod_ext, acc_base, acc_nx;
	logic acc_pos, acc_neg;

	logic signed [E_W-1:0] ebx, eby, ecx, ecy, ox, oy;
	logic take, last_v;
	logic signed [COORD_BITS-1:0] n2x, n2y;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && !in_stall;
	assign wdata     = {vertex_x, vertex_y};
	assign we0 = in_xfer && !body && (cnt0_q < CNT_W'(MAX_VERTICES));
	assign we1 = in_xfer && body && (cnt1_q < CNT_W'(MAX_VERTICES));

	gjk_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram0 (
		.clk(clk), .we(we0), .waddr(cnt0_q[ADDR_W-1:0]), .wdata(wdata),
		.raddr(vidx_q), .rdata(rd0)
	);
	gjk_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram1 (
		.clk(clk), .we(we1), .waddr(cnt1_q[ADDR_W-1:0]), .wdata(wdata),
		.raddr(vidx_q), .rdata(rd1)
	);

	assign rdx = body_q ? $signed(rd1[2*COORD_BITS-1:COORD_BITS])
	                    : $signed(rd0[2*COORD_BITS-1:COORD_BITS]);
	assign rdy = body_q ? $signed(rd1[COORD_BITS-1:0]) : $signed(rd0[COORD_BITS-1:0]);

	assign ebx = tri_q ? E_W'(p1x_q) - E_W'(pax_q) : E_W'(p0x_q) - E_W'(pax_q);
	assign eby = tri_q ? E_W'(p1y_q) - E_W'(pay_q) : E_W'(p0y_q) - E_W'(pay_q);
	assign ecx = E_W'(p0x_q) - E_W'(pax_q);
	assign ecy = E_W'(p0y_q) - E_W'(pay_q);
	assign ox  = -E_W'(pax_q);
	assign oy  = -E_W'(pay_q);

	always_comb begin
		mul_en  = 1'b0;
		mul_clr = 1'b0;
		mul_neg = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			S_INIT: begin
				mul_en  = (st_q != 3'd4);
				mul_clr = (st_q == 3'd0) || (st_q == 3'd2);
				mul_neg = (st_q == 3'd1) || (st_q == 3'd3);
				case (st_q)
					3'd0: begin mul_a = DIR_W'(s0x_q); mul_b = B_W'($signed({1'b0, cnt1_q})); end
					3'd1: begin mul_a = DIR_W'(s1x_q); mul_b = B_W'($signed({1'b0, cnt0_q})); end
					3'd2: begin mul_a = DIR_W'(s0y_q); mul_b = B_W'($signed({1'b0, cnt1_q})); end
					3'd3: begin mul_a = DIR_W'(s1y_q); mul_b = B_W'($signed({1'b0, cnt0_q})); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_SCAN: begin
				mul_en  = (st_q == 3'd1) || (st_q == 3'd2);
				mul_clr = (st_q == 3'd1);
				mul_a   = (st_q == 3'd1) ? dx_q : dy_q;
				mul_b   = (st_q == 3'd1) ? B_W'(rdx) : B_W'(rdy);
			end
			S_CHECK: begin
				mul_en  = (st_q == 3'd0) || (st_q == 3'd1);
				mul_clr = (st_q == 3'd0);
				mul_a   = (st_q == 3'd0) ? dx_q : dy_q;
				mul_b   = (st_q == 3'd0) ? B_W'(pax_q) : B_W'(pay_q);
			end
			S_CROSS: begin
				mul_en  = (st_q != 3'd6) && (tri_q || st_q < 3'd2);
				mul_clr = !st_q[0];
				mul_neg = st_q[0];
				case (tri_q ? st_q : st_q + 3'd4)
					3'd0: begin mul_a = DIR_W'(ebx); mul_b = B_W'(ecy); end
					3'd1: begin mul_a = DIR_W'(eby); mul_b = B_W'(ecx); end
					3'd2: begin mul_a = DIR_W'(ecx); mul_b = B_W'(oy); end
					3'd3: begin mul_a = DIR_W'(ecy); mul_b = B_W'(ox); end
					3'd4: begin mul_a = DIR_W'(ebx); mul_b = B_W'(oy); end
					3'd5: begin mul_a = DIR_W'(eby); mul_b = B_W'(ox); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_ext = ACC_W'(prod);
	assign acc_base = mul_clr ? '0 : acc_q;
	assign acc_nx   = mul_neg ? acc_base - prod_ext : acc_base + prod_ext;
	assign acc_pos  = !acc_q[ACC_W-1] && (acc_q != '0);
	assign acc_neg  = acc_q[ACC_W-1];

	assign take   = (vidx_q == '0) || (body_q ? (acc_q < best_q) : (acc_q > best_q));
	assign last_v = (CNT_W'(vidx_q) + CNT_W'(1)) == (body_q ? cnt1_q : cnt0_q);
	assign n2x    = take ? rdx : v2x_q;
	assign n2y    = take ? rdy : v2y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= '0;
			limit_q     <= LIMIT_RESET;
			iter_q      <= '0;
			cnt0_q      <= '0;
			cnt1_q      <= '0;
			s0x_q       <= '0;
			s0y_q       <= '0;
			s1x_q       <= '0;
			s1y_q       <= '0;
			drop_q      <= 1'b0;
			dx_q        <= '0;
			dy_q        <= '0;
			vidx_q      <= '0;
			body_q      <= 1'b0;
			init_q      <= 1'b0;
			tri_q       <= 1'b0;
			res_q       <= ST_SEPARATED;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (mul_en) begin
				acc_q <= acc_nx;
			end
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (we0) begin
							cnt0_q <= cnt0_q + CNT_W'(1);
							s0x_q  <= s0x_q + SUM_W'(vertex_x);
							s0y_q  <= s0y_q + SUM_W'(vertex_y);
						end else if (we1) begin
							cnt1_q <= cnt1_q + CNT_W'(1);
							s1x_q  <= s1x_q + SUM_W'(vertex_x);
							s1y_q  <= s1y_q + SUM_W'(vertex_y);
						end else begin
							drop_q <= 1'b1;
						end
						if (last) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					st_q <= '0;
					iter_q <= '0;
					if (drop_q) begin
						res_q   <= ST_DROPPED;
						state_q <= S_EMIT;
					end else if (cnt0_q == '0 || cnt1_q == '0) begin
						res_q   <= ST_EMPTY;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					if (st_q == 3'd2) begin
						dx_q <= acc_q[DIR_W-1:0];
					end
					if (st_q == 3'd4) begin
						dy_q <= acc_q[DIR_W-1:0];
						if (dx_q == '0 && acc_q == '0) begin
							dx_q <= DIR_W'(1);
						end
						init_q  <= 1'b1;
						tri_q   <= 1'b0;
						body_q  <= 1'b0;
						vidx_q  <= '0;
						st_q    <= '0;
						state_q <= S_SCAN;
					end else begin
						st_q <= st_q + 3'd1;
					end
				end
				S_SCAN: begin
					if (st_q == 3'd3) begin
						st_q <= '0;
						if (take) begin
							best_q <= acc_q;
							if (body_q) begin
								v2x_q <= rdx;
								v2y_q <= rdy;
							end else begin
								v1x_q <= rdx;
								v1y_q <= rdy;
							end
						end
						if (!last_v) begin
							vidx_q <= vidx_q + ADDR_W'(1);
						end else if (!body_q) begin
							body_q <= 1'b1;
							vidx_q <= '0;
						end else begin
							pax_q   <= P_W'(v1x_q) - P_W'(n2x);
							pay_q   <= P_W'(v1y_q) - P_W'(n2y);
							state_q <= S_CHECK;
						end
					end else begin
						st_q <= st_q + 3'd1;
					end
				end
				S_CHECK: begin
					if (st_q == 3'd2) begin
						st_q <= '0;
						if (!acc_pos) begin
							res_q   <= ST_SEPARATED;
							state_q <= S_EMIT;
						end else if (init_q) begin
							init_q  <= 1'b0;
							p0x_q   <= pax_q;
							p0y_q   <= pay_q;
							dx_q    <= -DIR_W'(pax_q);
							dy_q    <= -DIR_W'(pay_q);
							state_q <= S_LOOP;
						end else begin
							state_q <= S_CROSS;
						end
					end else begin
						st_q <= st_q + 3'd1;
					end
				end
				S_CROSS: begin
					st_q <= st_q + 3'd1;
					if (st_q == 3'd2) begin
						kpos_q <= acc_pos;
						kneg_q <= acc_neg;
					end
					if (st_q == 3'd4) begin
						g1pos_q <= acc_pos;
						g1neg_q <= acc_neg;
					end
					if (!tri_q && st_q == 3'd2) begin
						if (acc_pos) begin
							dx_q <= -DIR_W'(eby);
							dy_q <= DIR_W'(ebx);
						end else begin
							dx_q <= DIR_W'(eby);
							dy_q <= -DIR_W'(ebx);
						end
						p1x_q   <= pax_q;
						p1y_q   <= pay_q;
						tri_q   <= 1'b1;
						state_q <= S_LOOP;
					end
					if (tri_q && st_q == 3'd6) begin
						if (!((kpos_q && g1neg_q) || (kneg_q && g1pos_q))) begin
							if (kpos_q) begin
								dx_q <= -DIR_W'(ecy);
								dy_q <= DIR_W'(ecx);
							end else if (kneg_q) begin
								dx_q <= DIR_W'(ecy);
								dy_q <= -DIR_W'(ecx);
							end else begin
								dx_q <= '0;
								dy_q <= '0;
							end
							p1x_q   <= pax_q;
							p1y_q   <= pay_q;
							state_q <= S_LOOP;
						end else if ((kpos_q && acc_pos) || (kneg_q && acc_neg)) begin
							res_q   <= ST_COLLISION;
							state_q <= S_EMIT;
						end else begin
							p0x_q <= p1x_q;
							p0y_q <= p1y_q;
							p1x_q <= pax_q;
							p1y_q <= pay_q;
							if (kpos_q) begin
								dx_q <= DIR_W'(eby);
								dy_q <= -DIR_W'(ebx);
							end else begin
								dx_q <= -DIR_W'(eby);
								dy_q <= DIR_W'(ebx);
							end
							state_q <= S_LOOP;
						end
					end
				end
				S_LOOP: begin
					st_q <= '0;
					if (iter_q < limit_q) begin
						iter_q  <= iter_q + LIM_W'(1);
						body_q  <= 1'b0;
						vidx_q  <= '0;
						state_q <= S_SCAN;
					end else begin
						res_q   <= ST_LIMIT;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						collision_q <= (res_q == ST_COLLISION);
						status_q    <= res_q;
						iters_q     <= iter_q;
						cnt0_q      <= '0;
						cnt1_q      <= '0;
						s0x_q       <= '0;
						s0y_q       <= '0;
						s1x_q       <= '0;
						s1y_q       <= '0;
						drop_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign collision       = collision_q;
	assign status          = status_q;
	assign iterations_used = iters_q;

	a_collision_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (collision == (status == ST_COLLISION)))
		else $error("collision flag disagrees with status");

	a_no_iters_early: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY || status == ST_DROPPED) |-> iterations_used == 8'd0)
		else $error("iterations reported without a test run");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> iter_q <= limit_q)
		else $error("iteration count beyond limit");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall)
		else $error("input not held off after final vertex");
endmodule
`default_nettype wire

@@ sim/tb_gjk_polygon_overlap_test_2d_unit.sv @@
// Testbench for the 2D GJK overlap unit: streams polygon pairs and checks each overlap result.
`default_nettype none
module tb_gjk_polygon_overlap_test_2d_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import gjk_pkg::*;

	typedef struct {
		logic                         body;
		logic signed [COORD_BITS-1:0] vx;
		logic signed [COORD_BITS-1:0] vy;
		logic                         last;
	} vertex_t;

	typedef struct {
		logic       collision;
		logic [2:0] status;
		logic [7:0] iters;
	} verdict_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         body;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         last;
	logic                         out_valid;
	logic                         out_stall;
	logic                         collision;
	logic [2:0]                   status;
	logic [7:0]                   iterations_used;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [LIM_W-1:0]             cfg_data;

	gjk_polygon_overlap_test_2d_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.body(body), .vertex_x(vertex_x), .vertex_y(vertex_y), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.collision(collision), .status(status), .iterations_used(iterations_used),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	vertex_t  vertex_q[$];
	verdict_t verdict_q[$];
	int       errors = 0;
	int       tx_idle_pct = 0;
	int       rx_idle_pct = 0;
	bit       rx_hold = 0;
	bit       hold_phase = 0;

	// shadow of the unit's polygon stores and limit
	longint   poly_x[2][MAX_VERTICES];
	longint   poly_y[2][MAX_VERTICES];
	int       poly_n[2];
	longint   poly_sx[2];
	longint   poly_sy[2];
	bit       poly_dropped;
	int       iter_limit;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint sgn(input longint v);
		return (v > 0) - (v < 0);
	endfunction

	function automatic int furthest(input int b, input longint dx, input longint dy);
		int     best;
		longint top;
		longint p;
		best = 0;
		top = dx * poly_x[b][0] + dy * poly_y[b][0];
		for (int i = 1; i < poly_n[b]; i++) begin
			p = dx * poly_x[b][i] + dy * poly_y[b][i];
			if (p > top) begin
				top = p;
				best = i;
			end
		end
		return best;
	endfunction

	function automatic void minkowski_support(input longint dx, input longint dy,
			output longint px, output longint py);
		int i;
		int j;
		i = furthest(0, dx, dy);
		j = furthest(1, -dx, -dy);
		px = poly_x[0][i] - poly_x[1][j];
		py = poly_y[0][i] - poly_y[1][j];
	endfunction

	function automatic logic [2:0] overlap_search(output int iters);
		longint dx, dy, ax, ay, ox, oy, abx, aby, acx, acy, k, s;
		longint spx[3];
		longint spy[3];
		int     idx;
		idx = 0;
		iters = 0;
		dx = poly_n[1] * poly_sx[0] - poly_n[0] * poly_sx[1];
		dy = poly_n[1] * poly_sy[0] - poly_n[0] * poly_sy[1];
		if (dx == 0 && dy == 0) dx = 1;
		minkowski_support(dx, dy, ax, ay);
		spx[0] = ax;
		spy[0] = ay;
		if (dx * ax + dy * ay <= 0) return ST_SEPARATED;
		dx = -ax;
		dy = -ay;
		while (iters < iter_limit) begin
			iters++;
			minkowski_support(dx, dy, ax, ay);
			idx++;
			spx[idx] = ax;
			spy[idx] = ay;
			if (dx * ax + dy * ay <= 0) return ST_SEPARATED;
			ox = -ax;
			oy = -ay;
			if (idx < 2) begin
				abx = spx[0] - ax;
				aby = spy[0] - ay;
				k = sgn(abx * oy - aby * ox);
				if (k == 0) begin
					dx = aby;
					dy = -abx;
				end else begin
					dx = -k * aby;
					dy = k * abx;
				end
				continue;
			end
			abx = spx[1] - ax;
			aby = spy[1] - ay;
			acx = spx[0] - ax;
			acy = spy[0] - ay;
			k = sgn(abx * acy - aby * acx);
			s = k * sgn(-acy * ox + acx * oy);
			if (s >= 0) begin
				dx = -k * acy;
				dy = k * acx;
			end else begin
				s = -k * sgn(-aby * ox + abx * oy);
				if (s < 0) return ST_COLLISION;
				spx[0] = spx[1];
				spy[0] = spy[1];
				dx = k * aby;
				dy = -k * abx;
			end
			spx[1] = spx[2];
			spy[1] = spy[2];
			idx--;
		end
		return ST_LIMIT;
	endfunction

	function automatic void absorb_vertex(input vertex_t v);
		verdict_t r;
		int       b;
		int       it;
		b = v.body;
		if (poly_n[b] < MAX_VERTICES) begin
			poly_x[b][poly_n[b]] = v.vx;
			poly_y[b][poly_n[b]] = v.vy;
			poly_n[b]++;
			poly_sx[b] += v.vx;
			poly_sy[b] += v.vy;
		end else begin
			poly_dropped = 1;
		end
		if (!v.last) return;
		it = 0;
		if (poly_dropped) r.status = ST_DROPPED;
		else if (poly_n[0] == 0 || poly_n[1] == 0) r.status = ST_EMPTY;
		else r.status = overlap_search(it);
		r.collision = (r.status == ST_COLLISION);
		r.iters = it[7:0];
		verdict_q = {verdict_q, r};
		poly_n = '{0, 0};
		poly_sx = '{0, 0};
		poly_sy = '{0, 0};
		poly_dropped = 0;
	endfunction

	always @(posedge clk) begin
		verdict_t w;
		if (in_valid && !in_stall) begin
			absorb_vertex(vertex_q.pop_front());
			in_valid <= 1'b0;
		end
		if (out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				report("unexpected result, status", status, -1);
			end else begin
				w = verdict_q.pop_front();
				if (collision !== w.collision) report("collision", collision, w.collision);
				if (status !== w.status) report("status", status, w.status);
				if (iterations_used !== w.iters) report("iterations_used", iterations_used, w.iters);
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
		if (!in_valid) begin
			if (vertex_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				body     <= vertex_q[0].body;
				vertex_x <= vertex_q[0].vx;
				vertex_y <= vertex_q[0].vy;
				last     <= vertex_q[0].last;
			end
		end
	end

	function automatic logic signed [COORD_BITS-1:0] clamp(input longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic void add_vertex(input bit b, input longint x, input longint y,
			input bit l);
		vertex_t v;
		v.body = b;
		v.vx = clamp(x);
		v.vy = clamp(y);
		v.last = l;
		vertex_q = {vertex_q, v};
	endfunction

	// interleave two point clouds; the final vertex carries last
	function automatic void push_pair(input int n0, input int n1, input longint c0x,
			input longint c0y, input longint c1x, input longint c1y, input int r);
		int  left[2];
		int  b;
		left = '{n0, n1};
		while (left[0] + left[1] > 0) begin
			if (left[0] == 0) b = 1;
			else if (left[1] == 0) b = 0;
			else b = $urandom_range(0, 1);
			left[b]--;
			add_vertex(1'(b), (b ? c1x : c0x) + $signed($urandom_range(0, 2 * r)) - r,
				(b ? c1y : c0y) + $signed($urandom_range(0, 2 * r)) - r,
				left[0] + left[1] == 0);
		end
	endfunction

	function automatic void push_random_pairs(input int items);
		int     target;
		int     sel;
		int     r;
		longint cx, cy;
		target = vertex_q.size() + items;
		while (vertex_q.size() < target) begin
			sel = $urandom_range(0, 99);
			r = $urandom_range(1, 4000);
			cx = $signed($urandom_range(0, 40000)) - 20000;
			cy = $signed($urandom_range(0, 40000)) - 20000;
			if (sel < 80) begin
				push_pair($urandom_range(1, 6), $urandom_range(1, 6), cx, cy,
					cx + $signed($urandom_range(0, 4 * r)) - 2 * r,
					cy + $signed($urandom_range(0, 4 * r)) - 2 * r, r);
			end else if (sel < 82) begin
				push_pair($urandom_range(20, 64), $urandom_range(20, 64), cx, cy,
					cx + 300, cy - 200, r);
			end else if (sel < 86) begin
				if ($urandom_range(0, 1)) push_pair($urandom_range(1, 5), 0, cx, cy, 0, 0, r);
				else push_pair(0, $urandom_range(1, 5), 0, 0, cx, cy, r);
			end else if (sel < 88) begin
				push_pair($urandom_range(65, 67), $urandom_range(0, 2), cx, cy, cx, cy, r);
			end else if (sel < 93) begin
				push_pair($urandom_range(1, 3), $urandom_range(1, 3), 0, 0, 0, 0, 40000);
			end else begin
				// collinear or coincident points
				for (int i = $urandom_range(1, 5); i > 0; i--)
					add_vertex(1'($urandom_range(0, 1)), cx + 7 * i, cy + 3 * i, 0);
				add_vertex(1'($urandom_range(0, 1)), cx, cy, 1);
			end
		end
	endfunction

	task automatic write_limit(input logic [LIM_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		iter_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		while (vertex_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		while (!hold_phase) @(posedge clk);
		repeat (200) @(posedge clk);
		rx_hold = 1;
		repeat (3000) @(posedge clk);
		rx_hold = 0;
	end

	initial begin
		in_valid = 0;
		body = 0;
		vertex_x = 0;
		vertex_y = 0;
		last = 0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_data = 0;
		poly_n = '{0, 0};
		poly_sx = '{0, 0};
		poly_sy = '{0, 0};
		poly_dropped = 0;
		iter_limit = LIMIT_RESET;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		tx_idle_pct = 38;
		rx_idle_pct = 56;
		add_vertex(0, 0, 0, 0);
		add_vertex(1, 0, 0, 1);
		add_vertex(0, -32768, -32768, 0);
		add_vertex(0, 32767, -32768, 0);
		add_vertex(0, 32767, 32767, 0);
		add_vertex(1, -32768, 32767, 0);
		add_vertex(1, 0, -32768, 1);
		push_pair(4, 4, 0, 0, 100, 100, 500);
		push_pair(3, 3, -10000, 0, 10000, 0, 500);
		add_vertex(0, 5, 5, 0);
		add_vertex(0, 9, 2, 1);
		add_vertex(0, -5, 0, 0);
		add_vertex(0, 5, 0, 0);
		add_vertex(1, -3, 0, 0);
		add_vertex(1, 8, 0, 1);
		drain();
		write_limit(1);
		push_random_pairs(450);
		drain();

		tx_idle_pct = 56;
		rx_idle_pct = 38;
		write_limit(255);
		push_random_pairs(450);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_limit(0);
		push_random_pairs(150);
		drain();
		write_limit(100);
		hold_phase = 1;
		push_random_pairs(750);
		drain();

		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

@@ gjk_polygon_overlap_test_2d_unit.f @@
hdl/gjk_pkg.sv
hdl/gjk_ram.sv
hdl/gjk_polygon_overlap_test_2d_unit.sv
sim/tb_gjk_polygon_overlap_test_2d_unit.sv
